// ----- sv/precession_rotation_matrix_top_macros.svh -----
// assertion macros shared by the port checker
`ifndef PRECESSION_ROTATION_MATRIX_TOP_MACROS_SVH
`define PRECESSION_ROTATION_MATRIX_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define PRM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("port check failed");

// next-cycle implication, disabled during reset
`define PRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("port check failed");

`endif

// ----- sv/prm_pkg.sv -----
// shared types, constants and rounding helpers for the precession matrix
`timescale 1ns / 1ps

package prm_pkg;

    typedef logic signed [63:0] q60_t;

    typedef struct packed {
        logic [5:0] shift;
        logic       rnd;
    } mul_mode_t;

    localparam int TIME_FRAC_BITS = 28;
    localparam int OUT_FRAC_BITS  = 30;
    localparam int FB             = 60;

    localparam int MUL_LAT    = 4;
    localparam int SC_LAT     = 7 * MUL_LAT + 4;
    localparam int PIPE_DEPTH = 6 * MUL_LAT + SC_LAT + 4;

    localparam q60_t ONE_Q   = 64'sd1 <<< FB;
    localparam q60_t T_LIMIT = 64'sd1 <<< 43;
    localparam q60_t KM      = 64'sd23444151071829;

    // time scaling to 40 fraction bits
    localparam int T_SHIFT = 40 - TIME_FRAC_BITS;
    localparam int T_LSH   = (T_SHIFT >= 0) ? (T_SHIFT & 31) : 0;
    localparam int T_RSH   = (T_SHIFT < 0) ? ((-T_SHIFT) & 63) : 1;

    // output scaling from 60 fraction bits
    localparam int O_SHIFT = FB - OUT_FRAC_BITS;
    localparam int O_RSH   = (O_SHIFT > 0) ? (O_SHIFT & 63) : 1;
    localparam int O_LSH   = (O_SHIFT < 0) ? ((-O_SHIFT) & 7) : 0;

    localparam q60_t OUT_MAX = 64'sd2147483647;
    localparam q60_t OUT_MIN = -64'sd2147483648;

    localparam int ANG_ZETA  = 0;
    localparam int ANG_THETA = 1;
    localparam int ANG_Z     = 2;

    // polynomial coefficients in micro-arcseconds, per angle, t^1..t^3
    localparam q60_t ANG_COEF [3][3] = '{
        '{64'sd2306218100, 64'sd301880, 64'sd17998},
        '{64'sd2004310900, -64'sd426650, -64'sd41833},
        '{64'sd2306218100, 64'sd1094680, 64'sd18203}
    };

    // reciprocals for exact truncating division of values below 2^55
    localparam int   RCP_SHIFT = 61;
    localparam q60_t RCP_6  = ((64'sd1 <<< RCP_SHIFT) + 64'sd5) / 64'sd6;
    localparam q60_t RCP_12 = ((64'sd1 <<< RCP_SHIFT) + 64'sd11) / 64'sd12;
    localparam q60_t RCP_20 = ((64'sd1 <<< RCP_SHIFT) + 64'sd19) / 64'sd20;
    localparam q60_t RCP_30 = ((64'sd1 <<< RCP_SHIFT) + 64'sd29) / 64'sd30;
    localparam q60_t RCP_42 = ((64'sd1 <<< RCP_SHIFT) + 64'sd41) / 64'sd42;
    localparam q60_t RCP_56 = ((64'sd1 <<< RCP_SHIFT) + 64'sd55) / 64'sd56;

    localparam mul_mode_t MODE_Q60 = '{shift: 6'd60, rnd: 1'b1};
    localparam mul_mode_t MODE_T40 = '{shift: 6'd40, rnd: 1'b1};
    localparam mul_mode_t MODE_T20 = '{shift: 6'd20, rnd: 1'b1};
    localparam mul_mode_t MODE_KM  = '{shift: 6'd42, rnd: 1'b1};
    localparam mul_mode_t MODE_DIV = '{shift: 6'(RCP_SHIFT), rnd: 1'b0};

    // round to nearest, ties away from zero, dropping s fraction bits
    function automatic q60_t round_shift(input q60_t v, input logic [5:0] s);
        logic [63:0] mag;
        logic [63:0] q;
        begin
            mag = v[63] ? (~v + 64'd1) : v;
            q   = (mag + (64'd1 << (s - 6'd1))) >> s;
            q[63] = 1'b0;
            return v[63] ? q60_t'(~q + 64'd1) : q60_t'(q);
        end
    endfunction

    // scale to the output format and saturate to 32 bits
    function automatic logic signed [31:0] out_field(input q60_t v);
        q60_t w;
        begin
            w = v;
            if (O_SHIFT > 0)
                w = round_shift(v, 6'(O_RSH));
            else if (O_SHIFT < 0)
                w = v <<< O_LSH;
            if (w > OUT_MAX)
                w = OUT_MAX;
            if (w < OUT_MIN)
                w = OUT_MIN;
            return w[31:0];
        end
    endfunction

endpackage

// ----- sv/prm_mul.sv -----
// four-stage 64x64 sign-magnitude multiplier with a shift that rounds or truncates by mode
`timescale 1ns / 1ps

module prm_mul (
    input  logic                clk,
    input  logic                en,
    input  prm_pkg::mul_mode_t  mode,
    input  prm_pkg::q60_t       a,
    input  prm_pkg::q60_t       b,
    output prm_pkg::q60_t       p
);

    logic [63:0]  ua_reg;
    logic [63:0]  ub_reg;
    logic         neg1_reg;
    logic [63:0]  p00_reg;
    logic [63:0]  p01_reg;
    logic [63:0]  p10_reg;
    logic [63:0]  p11_reg;
    logic         neg2_reg;
    logic [127:0] prod_reg;
    logic         neg3_reg;
    prm_pkg::q60_t p_reg;

    logic [127:0] rnd_add;
    logic [127:0] prod_sh;
    logic [63:0]  q;

    always_comb
    begin
        rnd_add = mode.rnd ? (128'd1 << (mode.shift - 6'd1)) : 128'd0;
        prod_sh = (prod_reg + rnd_add) >> mode.shift;
        q       = {1'b0, prod_sh[62:0]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // magnitudes
            ua_reg   <= a[63] ? (~a + 64'd1) : a;
            ub_reg   <= b[63] ? (~b + 64'd1) : b;
            neg1_reg <= a[63] ^ b[63];
            // partial products
            p00_reg  <= ua_reg[31:0] * ub_reg[31:0];
            p01_reg  <= ua_reg[31:0] * ub_reg[63:32];
            p10_reg  <= ua_reg[63:32] * ub_reg[31:0];
            p11_reg  <= ua_reg[63:32] * ub_reg[63:32];
            neg2_reg <= neg1_reg;
            // full product
            prod_reg <= {64'd0, p00_reg} + {32'd0, p01_reg, 32'd0}
                      + {32'd0, p10_reg, 32'd0} + {p11_reg, 64'd0};
            neg3_reg <= neg2_reg;
            // round, shift, restore sign
            p_reg    <= neg3_reg ? prm_pkg::q60_t'(~q + 64'd1) : prm_pkg::q60_t'(q);
        end
    end

    assign p = p_reg;

endmodule

// ----- sv/prm_sincos.sv -----
// pipelined sine and cosine series for small angles in q60
`timescale 1ns / 1ps

module prm_sincos (
    input  logic           clk,
    input  logic           en,
    input  prm_pkg::q60_t  x,
    output prm_pkg::q60_t  s_out,
    output prm_pkg::q60_t  c_out
);

    localparam int L = prm_pkg::MUL_LAT;

    prm_pkg::q60_t x2;
    prm_pkg::q60_t x_dly_reg [6*L+3];
    prm_pkg::q60_t x2_dly_reg [5*L+3];

    prm_pkg::q60_t a42, b56, pu1, pv1, a20, b30, pu2, pv2, a6, b12, ps, pc;
    prm_pkg::q60_t u1_reg, v1_reg, u2_reg, v2_reg, u3_reg, v3_reg;
    prm_pkg::q60_t s_reg, c_reg;

    prm_mul u_x2  (.clk(clk), .en(en), .mode(prm_pkg::MODE_Q60), .a(x), .b(x), .p(x2));

    prm_mul u_d42 (.clk(clk), .en(en), .mode(prm_pkg::MODE_DIV), .a(x2),
                   .b(prm_pkg::RCP_42), .p(a42));
    prm_mul u_d56 (.clk(clk), .en(en), .mode(prm_pkg::MODE_DIV), .a(x2),
                   .b(prm_pkg::RCP_56), .p(b56));

    prm_mul u_mu1 (.clk(clk), .en(en), .mode(prm_pkg::MODE_Q60), .a(x2_dly_reg[L]),
                   .b(u1_reg), .p(pu1));
    prm_mul u_mv1 (.clk(clk), .en(en), .mode(prm_pkg::MODE_Q60), .a(x2_dly_reg[L]),
                   .b(v1_reg), .p(pv1));
    prm_mul u_d20 (.clk(clk), .en(en), .mode(prm_pkg::MODE_DIV), .a(pu1),
                   .b(prm_pkg::RCP_20), .p(a20));
    prm_mul u_d30 (.clk(clk), .en(en), .mode(prm_pkg::MODE_DIV), .a(pv1),
                   .b(prm_pkg::RCP_30), .p(b30));

    prm_mul u_mu2 (.clk(clk), .en(en), .mode(prm_pkg::MODE_Q60), .a(x2_dly_reg[3*L+1]),
                   .b(u2_reg), .p(pu2));
    prm_mul u_mv2 (.clk(clk), .en(en), .mode(prm_pkg::MODE_Q60), .a(x2_dly_reg[3*L+1]),
                   .b(v2_reg), .p(pv2));
    prm_mul u_d6  (.clk(clk), .en(en), .mode(prm_pkg::MODE_DIV), .a(pu2),
                   .b(prm_pkg::RCP_6), .p(a6));
    prm_mul u_d12 (.clk(clk), .en(en), .mode(prm_pkg::MODE_DIV), .a(pv2),
                   .b(prm_pkg::RCP_12), .p(b12));

    prm_mul u_ms  (.clk(clk), .en(en), .mode(prm_pkg::MODE_Q60), .a(x_dly_reg[6*L+2]),
                   .b(u3_reg), .p(ps));
    prm_mul u_mc  (.clk(clk), .en(en), .mode(prm_pkg::MODE_Q60), .a(x2_dly_reg[5*L+2]),
                   .b(v3_reg), .p(pc));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_dly_reg[0]  <= x;
            for (int i = 1; i < 6*L+3; i++)
                x_dly_reg[i] <= x_dly_reg[i-1];
            x2_dly_reg[0] <= x2;
            for (int i = 1; i < 5*L+3; i++)
                x2_dly_reg[i] <= x2_dly_reg[i-1];
            u1_reg <= prm_pkg::ONE_Q - a42;
            v1_reg <= prm_pkg::ONE_Q - b56;
            u2_reg <= prm_pkg::ONE_Q - a20;
            v2_reg <= prm_pkg::ONE_Q - b30;
            u3_reg <= prm_pkg::ONE_Q - a6;
            v3_reg <= prm_pkg::ONE_Q - b12;
            s_reg  <= ps;
            // halve toward zero
            c_reg  <= prm_pkg::ONE_Q - ((pc + {63'd0, pc[63]}) >>> 1);
        end
    end

    assign s_out = s_reg;
    assign c_out = c_reg;

endmodule

// ----- sv/precession_rotation_matrix_top.sv -----
// precession rotation matrix pipeline: epoch in, nine matrix entries out
// throughput: one word per cycle; in_ready drops only when the output skid stage is full
// the depth is set by the 4-stage 64x64 multipliers chained through the series
// reset clears valid bits and the output/skid flags; data registers are not reset
`timescale 1ns / 1ps

module precession_rotation_matrix_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  t_centuries,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  m00,
    output logic signed [31:0]  m01,
    output logic signed [31:0]  m02,
    output logic signed [31:0]  m10,
    output logic signed [31:0]  m11,
    output logic signed [31:0]  m12,
    output logic signed [31:0]  m20,
    output logic signed [31:0]  m21,
    output logic signed [31:0]  m22
);

    localparam int L     = prm_pkg::MUL_LAT;
    localparam int DEPTH = prm_pkg::PIPE_DEPTH;

    // first-level product slots
    localparam int P_A      = 0;  // cos theta * cos z
    localparam int P_B      = 1;  // cos theta * sin z
    localparam int P_SZ_SZE = 2;
    localparam int P_SZ_CZE = 3;
    localparam int P_ST_CZ  = 4;
    localparam int P_SZE_CZ = 5;
    localparam int P_CZ_CZE = 6;
    localparam int P_ST_SZ  = 7;
    localparam int P_ST_CZE = 8;
    localparam int P_ST_SZE = 9;

    // second-level product slots
    localparam int Q_A_CZE = 0;
    localparam int Q_A_SZE = 1;
    localparam int Q_B_CZE = 2;
    localparam int Q_B_SZE = 3;

    // pipeline advance: stalls only when the skid stage holds a word
    logic en;
    logic vld_reg [DEPTH];

    // stage 1: time in q40, clamped
    prm_pkg::q60_t t_ext, t_sh, t1_next, t1_reg;
    prm_pkg::q60_t t1_dly_reg [2*L];
    prm_pkg::q60_t t2, t3;
    prm_pkg::q60_t t2_dly_reg [L];
    prm_pkg::q60_t t_pow [3];

    // angle polynomial terms, sums and radians
    prm_pkg::q60_t term [3][3];
    prm_pkg::q60_t sum_reg [3];
    prm_pkg::q60_t ang [3];
    prm_pkg::q60_t s_ang [3];
    prm_pkg::q60_t c_ang [3];

    // matrix products
    prm_pkg::q60_t l1_a [10];
    prm_pkg::q60_t l1_b [10];
    prm_pkg::q60_t l1_p [10];
    prm_pkg::q60_t l1_dly_reg [L][10];
    prm_pkg::q60_t sze_dly_reg [L];
    prm_pkg::q60_t cze_dly_reg [L];
    prm_pkg::q60_t ct_dly_reg [2*L];
    prm_pkg::q60_t l2_a [4];
    prm_pkg::q60_t l2_b [4];
    prm_pkg::q60_t l2_p [4];

    prm_pkg::q60_t comb_next [9];
    prm_pkg::q60_t comb_reg [9];
    logic signed [31:0] fld_reg [9];

    // output register and skid stage
    logic               out_v_reg, out_v_next;
    logic               skid_v_reg, skid_v_next;
    logic signed [31:0] out_reg [9];
    logic signed [31:0] skid_reg [9];
    logic               push, pop;

    assign en       = !skid_v_reg;
    assign in_ready = en;

    // time scaling and clamp to eight centuries
    always_comb
    begin
        t_ext = {{32{t_centuries[31]}}, t_centuries};
        if (prm_pkg::T_SHIFT >= 0)
            t_sh = t_ext <<< prm_pkg::T_LSH;
        else
            t_sh = prm_pkg::round_shift(t_ext, 6'(prm_pkg::T_RSH));
        t1_next = t_sh;
        if (t_sh > prm_pkg::T_LIMIT)
            t1_next = prm_pkg::T_LIMIT;
        if (t_sh < -prm_pkg::T_LIMIT)
            t1_next = -prm_pkg::T_LIMIT;
    end

    // valid bits travel alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // t^2 and t^3 in q40
    prm_mul u_t2 (.clk(clk), .en(en), .mode(prm_pkg::MODE_T40), .a(t1_reg), .b(t1_reg),
                  .p(t2));
    prm_mul u_t3 (.clk(clk), .en(en), .mode(prm_pkg::MODE_T40), .a(t2),
                  .b(t1_dly_reg[L-1]), .p(t3));

    assign t_pow[0] = t1_dly_reg[2*L-1];
    assign t_pow[1] = t2_dly_reg[L-1];
    assign t_pow[2] = t3;

    // nine terms, three angles, radians, sine and cosine
    for (genvar ga = 0; ga < 3; ga++)
    begin : g_ang
        for (genvar gk = 0; gk < 3; gk++)
        begin : g_term
            prm_mul u_term (.clk(clk), .en(en), .mode(prm_pkg::MODE_T20),
                            .a(prm_pkg::ANG_COEF[ga][gk]), .b(t_pow[gk]),
                            .p(term[ga][gk]));
        end

        // micro-arcseconds q20 to radians q60
        prm_mul u_rad (.clk(clk), .en(en), .mode(prm_pkg::MODE_KM), .a(sum_reg[ga]),
                       .b(prm_pkg::KM), .p(ang[ga]));

        prm_sincos u_sc (.clk(clk), .en(en), .x(ang[ga]), .s_out(s_ang[ga]),
                         .c_out(c_ang[ga]));
    end

    // first-level matrix products
    always_comb
    begin
        l1_a[P_A]      = c_ang[prm_pkg::ANG_THETA];
        l1_b[P_A]      = c_ang[prm_pkg::ANG_Z];
        l1_a[P_B]      = c_ang[prm_pkg::ANG_THETA];
        l1_b[P_B]      = s_ang[prm_pkg::ANG_Z];
        l1_a[P_SZ_SZE] = s_ang[prm_pkg::ANG_Z];
        l1_b[P_SZ_SZE] = s_ang[prm_pkg::ANG_ZETA];
        l1_a[P_SZ_CZE] = s_ang[prm_pkg::ANG_Z];
        l1_b[P_SZ_CZE] = c_ang[prm_pkg::ANG_ZETA];
        l1_a[P_ST_CZ]  = s_ang[prm_pkg::ANG_THETA];
        l1_b[P_ST_CZ]  = c_ang[prm_pkg::ANG_Z];
        l1_a[P_SZE_CZ] = s_ang[prm_pkg::ANG_ZETA];
        l1_b[P_SZE_CZ] = c_ang[prm_pkg::ANG_Z];
        l1_a[P_CZ_CZE] = c_ang[prm_pkg::ANG_Z];
        l1_b[P_CZ_CZE] = c_ang[prm_pkg::ANG_ZETA];
        l1_a[P_ST_SZ]  = s_ang[prm_pkg::ANG_THETA];
        l1_b[P_ST_SZ]  = s_ang[prm_pkg::ANG_Z];
        l1_a[P_ST_CZE] = s_ang[prm_pkg::ANG_THETA];
        l1_b[P_ST_CZE] = c_ang[prm_pkg::ANG_ZETA];
        l1_a[P_ST_SZE] = s_ang[prm_pkg::ANG_THETA];
        l1_b[P_ST_SZE] = s_ang[prm_pkg::ANG_ZETA];
    end

    for (genvar gi = 0; gi < 10; gi++)
    begin : g_l1
        prm_mul u_l1 (.clk(clk), .en(en), .mode(prm_pkg::MODE_Q60), .a(l1_a[gi]),
                      .b(l1_b[gi]), .p(l1_p[gi]));
    end

    // second-level products: the left-to-right triple products
    always_comb
    begin
        l2_a[Q_A_CZE] = l1_p[P_A];
        l2_b[Q_A_CZE] = cze_dly_reg[L-1];
        l2_a[Q_A_SZE] = l1_p[P_A];
        l2_b[Q_A_SZE] = sze_dly_reg[L-1];
        l2_a[Q_B_CZE] = l1_p[P_B];
        l2_b[Q_B_CZE] = cze_dly_reg[L-1];
        l2_a[Q_B_SZE] = l1_p[P_B];
        l2_b[Q_B_SZE] = sze_dly_reg[L-1];
    end

    for (genvar gj = 0; gj < 4; gj++)
    begin : g_l2
        prm_mul u_l2 (.clk(clk), .en(en), .mode(prm_pkg::MODE_Q60), .a(l2_a[gj]),
                      .b(l2_b[gj]), .p(l2_p[gj]));
    end

    // matrix entries before output scaling
    always_comb
    begin
        comb_next[0] = l2_p[Q_A_CZE] - l1_dly_reg[L-1][P_SZ_SZE];
        comb_next[1] = -l2_p[Q_A_SZE] - l1_dly_reg[L-1][P_SZ_CZE];
        comb_next[2] = -l1_dly_reg[L-1][P_ST_CZ];
        comb_next[3] = l2_p[Q_B_CZE] + l1_dly_reg[L-1][P_SZE_CZ];
        comb_next[4] = l1_dly_reg[L-1][P_CZ_CZE] - l2_p[Q_B_SZE];
        comb_next[5] = -l1_dly_reg[L-1][P_ST_SZ];
        comb_next[6] = l1_dly_reg[L-1][P_ST_CZE];
        comb_next[7] = -l1_dly_reg[L-1][P_ST_SZE];
        comb_next[8] = ct_dly_reg[2*L-1];
    end

    // data stages, advanced together with the valid bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg <= t1_next;
            t1_dly_reg[0] <= t1_reg;
            for (int i = 1; i < 2*L; i++)
                t1_dly_reg[i] <= t1_dly_reg[i-1];
            t2_dly_reg[0] <= t2;
            for (int i = 1; i < L; i++)
                t2_dly_reg[i] <= t2_dly_reg[i-1];
            for (int a = 0; a < 3; a++)
                sum_reg[a] <= term[a][0] + term[a][1] + term[a][2];
            l1_dly_reg[0] <= l1_p;
            sze_dly_reg[0] <= s_ang[prm_pkg::ANG_ZETA];
            cze_dly_reg[0] <= c_ang[prm_pkg::ANG_ZETA];
            for (int i = 1; i < L; i++)
            begin
                l1_dly_reg[i]  <= l1_dly_reg[i-1];
                sze_dly_reg[i] <= sze_dly_reg[i-1];
                cze_dly_reg[i] <= cze_dly_reg[i-1];
            end
            ct_dly_reg[0] <= c_ang[prm_pkg::ANG_THETA];
            for (int i = 1; i < 2*L; i++)
                ct_dly_reg[i] <= ct_dly_reg[i-1];
            comb_reg <= comb_next;
            for (int k = 0; k < 9; k++)
                fld_reg[k] <= prm_pkg::out_field(comb_reg[k]);
        end
    end

    // output register with a one-word skid behind it
    assign push = en && vld_reg[DEPTH-1];
    assign pop  = out_v_reg && out_ready;

    always_comb
    begin
        out_v_next  = out_v_reg;
        skid_v_next = skid_v_reg;
        if (skid_v_reg)
        begin
            if (pop)
                skid_v_next = 1'b0;
        end
        else if (push)
        begin
            out_v_next = 1'b1;
            if (out_v_reg && !pop)
                skid_v_next = 1'b1;
        end
        else if (pop)
        begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (push)
        begin
            if (out_v_reg && !pop)
                skid_reg <= fld_reg;
            else
                out_reg <= fld_reg;
        end
    end

    assign out_valid = out_v_reg;
    assign m00 = out_reg[0];
    assign m01 = out_reg[1];
    assign m02 = out_reg[2];
    assign m10 = out_reg[3];
    assign m11 = out_reg[4];
    assign m12 = out_reg[5];
    assign m20 = out_reg[6];
    assign m21 = out_reg[7];
    assign m22 = out_reg[8];

endmodule

// ----- sv/prm_chk.sv -----
// port-level checker for the precession matrix block, bound to the top level
`timescale 1ns / 1ps

`include "precession_rotation_matrix_top_macros.svh"

module prm_chk (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic signed [31:0]  m00,
    input logic signed [31:0]  m22
);

    // a stalled word stays
    `PRM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    // a stalled word keeps its payload
    `PRM_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(m00) && $stable(m22))
    // input back-pressure only while a word waits at the output
    `PRM_ASSERT_NOW(a_stall_has_word, clk, rst_n, !in_ready, out_valid)
    // ready only drops after the output was stalled
    `PRM_ASSERT_NOW(a_stall_cause, clk, rst_n, $fell(in_ready), $past(out_valid && !out_ready))

endmodule

bind precession_rotation_matrix_top prm_chk u_prm_chk (.*);

// ----- dv/precession_matrix_checker.sv -----
// checker for the precession matrix block: predicts each matrix and compares the words
`timescale 1ns / 1ps

module precession_matrix_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [31:0] t_centuries,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] m00,
    input  logic signed [31:0] m01,
    input  logic signed [31:0] m02,
    input  logic signed [31:0] m10,
    input  logic signed [31:0] m11,
    input  logic signed [31:0] m12,
    input  logic signed [31:0] m20,
    input  logic signed [31:0] m21,
    input  logic signed [31:0] m22,
    output int                 fail_count,
    output int                 pending
);

    typedef logic [8:0][31:0] matrix_t;

    matrix_t expected_mats[$];
    int      mismatch_count;

    // product scaled down by 2^s, rounded half away from zero
    function automatic longint mul_round(input longint a, input longint b, input int s);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        logic [63:0]  q;
        bit           neg;
        begin
            neg = (a < 0) != (b < 0);
            ua  = a[63] ? 64'(-a) : 64'(a);
            ub  = b[63] ? 64'(-b) : 64'(b);
            p   = {64'd0, ua} * {64'd0, ub};
            p   = p + (128'd1 << (s - 1));
            q   = 64'(p >> s);
            q[63] = 1'b0;
            return neg ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic longint mul60(input longint a, input longint b);
        return mul_round(a, b, prm_pkg::FB);
    endfunction

    // polynomial in micro-arcseconds, then radians with 60 fraction bits
    function automatic longint angle_rad(input longint c1, input longint c2, input longint c3,
                                         input longint t1, input longint t2, input longint t3);
        longint acc;
        begin
            acc = mul_round(c1, t1, 20) + mul_round(c2, t2, 20) + mul_round(c3, t3, 20);
            return mul_round(acc, prm_pkg::KM, 42);
        end
    endfunction

    task automatic series_sin_cos(input longint x, output longint s, output longint c);
        longint x2;
        longint u;
        longint v;
        begin
            x2 = mul60(x, x);
            u  = prm_pkg::ONE_Q - x2 / 42;
            v  = prm_pkg::ONE_Q - x2 / 56;
            u  = prm_pkg::ONE_Q - mul60(x2, u) / 20;
            u  = prm_pkg::ONE_Q - mul60(x2, u) / 6;
            s  = mul60(x, u);
            v  = prm_pkg::ONE_Q - mul60(x2, v) / 30;
            v  = prm_pkg::ONE_Q - mul60(x2, v) / 12;
            v  = prm_pkg::ONE_Q - mul60(x2, v) / 2;
            c  = v;
        end
    endtask

    function automatic logic [31:0] to_entry(input longint v);
        longint w;
        begin
            w = v;
            if (prm_pkg::FB - prm_pkg::OUT_FRAC_BITS > 0)
                w = mul_round(v, 1, prm_pkg::FB - prm_pkg::OUT_FRAC_BITS);
            else if (prm_pkg::FB - prm_pkg::OUT_FRAC_BITS < 0)
                w = v * (longint'(1) << ((prm_pkg::OUT_FRAC_BITS - prm_pkg::FB) & 7));
            if (w > 64'sd2147483647)
                w = 64'sd2147483647;
            if (w < -64'sd2147483648)
                w = -64'sd2147483648;
            return w[31:0];
        end
    endfunction

    task automatic predict_matrix(input logic signed [31:0] t, output matrix_t m);
        longint t1, t2, t3, zeta, theta, zz;
        longint sze, cze, sth, cth, sz, cz;
        begin
            if (prm_pkg::TIME_FRAC_BITS <= 40)
                t1 = longint'(t) * (longint'(1) << ((40 - prm_pkg::TIME_FRAC_BITS) & 31));
            else
                t1 = mul_round(longint'(t), 1, prm_pkg::TIME_FRAC_BITS - 40);
            if (t1 > prm_pkg::T_LIMIT)
                t1 = prm_pkg::T_LIMIT;
            if (t1 < -prm_pkg::T_LIMIT)
                t1 = -prm_pkg::T_LIMIT;
            t2 = mul_round(t1, t1, 40);
            t3 = mul_round(t2, t1, 40);
            zeta  = angle_rad(64'sd2306218100, 64'sd301880, 64'sd17998, t1, t2, t3);
            theta = angle_rad(64'sd2004310900, -64'sd426650, -64'sd41833, t1, t2, t3);
            zz    = angle_rad(64'sd2306218100, 64'sd1094680, 64'sd18203, t1, t2, t3);
            series_sin_cos(zeta, sze, cze);
            series_sin_cos(theta, sth, cth);
            series_sin_cos(zz, sz, cz);
            m[0] = to_entry(mul60(mul60(cth, cz), cze) - mul60(sz, sze));
            m[1] = to_entry(-mul60(mul60(cth, cz), sze) - mul60(sz, cze));
            m[2] = to_entry(-mul60(sth, cz));
            m[3] = to_entry(mul60(mul60(cth, sz), cze) + mul60(sze, cz));
            m[4] = to_entry(mul60(cz, cze) - mul60(mul60(cth, sz), sze));
            m[5] = to_entry(-mul60(sth, sz));
            m[6] = to_entry(mul60(sth, cze));
            m[7] = to_entry(-mul60(sth, sze));
            m[8] = to_entry(cth);
        end
    endtask

    initial
    begin
        fail_count     = 0;
        mismatch_count = 0;
        pending        = 0;
    end

    always @(posedge clk)
    begin
        matrix_t want;
        matrix_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_matrix(t_centuries, want);
                expected_mats.insert(expected_mats.size(), want);
            end
            if (out_valid && out_ready)
            begin
                got = {m22, m21, m20, m12, m11, m10, m02, m01, m00};
                if (expected_mats.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (mismatch_count < 10)
                        $display("unexpected word at %0t", $realtime);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_mats.pop_front();
                    for (int i = 0; i < 9; i++)
                    begin
                        if (got[i] !== want[i])
                        begin
                            if (mismatch_count < 10)
                                $display("m%0d%0d mismatch at %0t: expected %0d actual %0d",
                                         i / 3, i % 3, $realtime,
                                         $signed(want[i]), $signed(got[i]));
                            mismatch_count++;
                        end
                    end
                    if (got !== want)
                        fail_count <= fail_count + 1;
                end
            end
        end
        pending = expected_mats.size();
    end

endmodule

// ----- dv/tb_top.sv -----
// top of the precession matrix testbench: clock, reset, epoch stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] t_centuries;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    int                 fail_count;
    int                 pending;
    bit                 quiet;      // set near the end: no gaps, no stalls
    int                 stall_left;

    precession_rotation_matrix_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .t_centuries (t_centuries),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .m00 (m00), .m01 (m01), .m02 (m02),
        .m10 (m10), .m11 (m11), .m12 (m12),
        .m20 (m20), .m21 (m21), .m22 (m22)
    );

    // the checker sees both channels and keeps its own queue of predicted matrices
    precession_matrix_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .t_centuries (t_centuries),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .m00 (m00), .m01 (m01), .m02 (m02),
        .m10 (m10), .m11 (m11), .m12 (m12),
        .m20 (m20), .m21 (m21), .m22 (m22),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // 20 ns clock
    initial
        clk = 1'b0;
    always #10 clk = ~clk;

    // receiver back-pressure: random stall bursts, none once quiet
    always @(negedge clk)
    begin
        bit rdy;
        rdy = 1'b1;
        if (!quiet)
        begin
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                rdy = 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 7);
                rdy = 1'b0;
            end
        end
        out_ready <= rdy;
    end

    // one epoch word; valid stays high until the block takes it
    task automatic send_epoch(input logic signed [31:0] t);
        int gap;
        begin
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                in_valid <= 1'b0;
                gap = $urandom_range(1, 8);
                repeat (gap) @(negedge clk);
            end
            in_valid    <= 1'b1;
            t_centuries <= t;
            do
                @(posedge clk);
            while (!in_ready);
            @(negedge clk);
        end
    endtask

    // random epoch: within two centuries, full range, near the edges, or a power of two
    function automatic logic signed [31:0] pick_epoch();
        int sel;
        begin
            sel = $urandom_range(0, 99);
            if (sel < 40)
                return $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
            else if (sel < 70)
                return $urandom;
            else if (sel < 85)
                return (sel[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000)
                       + (sel[0] ? -$signed($urandom_range(0, 255))
                                 : $signed($urandom_range(0, 255)));
            else
                return 32'sd1 << $urandom_range(0, 31);
        end
    endfunction

    // safety net against a hung handshake
    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        logic signed [31:0] directed [$];
        quiet       = 1'b0;
        stall_left  = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        out_ready   = 1'b0;
        t_centuries = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: zero, unit steps, one and eight centuries, both extremes
        directed = '{32'sd0, 32'sd1, -32'sd1, 32'sh1000_0000, -32'sh1000_0000,
                     32'sh0800_0000, -32'sh0800_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                     32'sh8000_0001, 32'sh7FFF_FFFE, 32'sh5555_5555, 32'shAAAA_AAAA,
                     32'sh0000_FFFF, 32'shFFFF_0000, 32'sh4000_0000, -32'sh4000_0000,
                     32'sh0000_1000, -32'sh0000_1000, 32'sh2000_0000};
        foreach (directed[i])
            send_epoch(directed[i]);

        for (int n = 0; n < 1750; n++)
        begin
            // drain the pipeline once mid-run before going on
            if (n == 600)
            begin
                in_valid <= 1'b0;
                while (pending != 0)
                    @(negedge clk);
            end
            if (n == 1500)
                quiet = 1'b1;
            send_epoch(pick_epoch());
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/prm_pkg.sv
sv/prm_mul.sv
sv/prm_sincos.sv
sv/precession_rotation_matrix_top.sv
sv/prm_chk.sv
dv/precession_matrix_checker.sv
dv/tb_top.sv
